// ===== rtl/core/ntc_pkg.sv =====
// Package for the NTC beta-equation temperature converter.
// Holds shared types, constants, the log2 table function and the status codes.
// No dependencies.
package ntc_pkg;

  localparam int CODE_W   = 16;
  localparam int TEMP_W   = 18;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam logic [15:0] CODE_MAX = 16'd65534;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 18'sd100000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -18'sd27315;
  localparam logic [14:0] KELVIN_OFFSET_CENTI = 15'd27315;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RATIO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_REF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA     = 3'd5;

  // input channel payload
  typedef struct packed {
    logic [CODE_W-1:0] adc_code;
  } in_item_t;

  // result channel payload
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi_c;
    logic [STAT_W-1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [12:0]        adc_ref_mv;
    logic [12:0]        supply_mv;
    logic [19:0]        series_ohms;
    logic [19:0]        ntc_nominal_ohms;
    logic signed [14:0] ntc_ref_centi_c;
    logic [13:0]        beta_kelvin;
  } cfg_t;

  // front-to-back queue entry: classified item with its exact ratio terms
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [52:0]       num;
    logic [48:0]       den;
  } job_t;

  // log2(1 + i/n) in Q30, evaluated at elaboration for constant tables
  function automatic logic [31:0] log_rom_word(input int i, input int n);
    logic [63:0] z;
    logic [31:0] r;
    r = '0;
    if (i >= n) begin
      r = 32'h4000_0000;
    end else begin
      z = ((64'(n) + 64'(i)) << 31) / 64'(n);
      for (int k = 0; k < 30; k++) begin
        z = 64'((128'(z) * 128'(z)) >> 31);
        r = r << 1;
        if (z >= 64'h1_0000_0000) begin
          r[0] = 1'b1;
          z = z >> 1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ntc_stream_if.sv =====
// Valid/ready stream interface used by both channels.
// Parameterized payload type; depends on nothing.
interface ntc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ntc_beta_temperature_converter.sv =====
// Top level of the NTC beta-equation temperature converter.
// Depends on ntc_pkg, ntc_stream_if, ntc_front, ntc_fifo, ntc_back.
//
// channel | direction | payload
// in      | sink      | adc_code[15:0]
// out     | source    | temp_centi_c[17:0] signed, status[1:0]
// cfg     | write     | cfg_we, cfg_index[2:0], cfg_data[19:0]
//
// One code per cycle sustained while the output is not stalled; a result passes through
// the 2 front stages, the queue, the 10 log/beta stages,
// the 64-stage bit-per-stage divider and the output register.
// Synchronous active-low reset clears valid flags and loads register defaults.
// A stall at the output holds the back end; the queue absorbs the front end.
module ntc_beta_temperature_converter #(
  parameter int LOG_TABLE_ENTRIES = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ntc_stream_if.sink                    in_ch,
  ntc_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ntc_pkg::*;

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_ref_mv       <= 13'd3000;
      cfg_r.supply_mv        <= 13'd3300;
      cfg_r.series_ohms      <= 20'd100000;
      cfg_r.ntc_nominal_ohms <= 20'd100000;
      cfg_r.ntc_ref_centi_c  <= 15'sd2500;
      cfg_r.beta_kelvin      <= 14'd3950;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADC_REF:  cfg_r.adc_ref_mv       <= cfg_data[12:0];
        REG_SUPPLY:   cfg_r.supply_mv        <= cfg_data[12:0];
        REG_SERIES:   cfg_r.series_ohms      <= cfg_data;
        REG_NOMINAL:  cfg_r.ntc_nominal_ohms <= cfg_data;
        REG_REF_TEMP: cfg_r.ntc_ref_centi_c  <= $signed(cfg_data[14:0]);
        REG_BETA:     cfg_r.beta_kelvin      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic f_v, f_rdy, q_v, q_rdy;
  job_t f_job, q_job;

  ntc_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_code(in_ch.data.adc_code), .in_ready(in_ch.ready),
    .job_valid(f_v), .job(f_job), .job_ready(f_rdy)
  );

  ntc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_v), .wr_data(f_job), .wr_ready(f_rdy),
    .rd_valid(q_v), .rd_data(q_job), .rd_ready(q_rdy)
  );

  ntc_back #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .job_valid(q_v), .job(q_job), .job_ready(q_rdy),
    .res_valid(out_ch.valid), .res_temp(out_ch.data.temp_centi_c),
    .res_status(out_ch.data.status), .res_ready(out_ch.ready)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.status != 2'd3)
    else $error("illegal status code");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status != ST_OK) |-> out_ch.data.temp_centi_c == '0)
    else $error("error result carries nonzero temperature");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
endmodule

// ===== rtl/core/ntc_front.sv =====
// Front end: range checks and the exact ratio terms num and den.
// Depends on ntc_pkg. Two register stages, stall by a shared enable.
module ntc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ntc_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  input  logic [15:0]          in_code,
  output logic                 in_ready,
  output logic                 job_valid,
  output ntc_pkg::job_t        job,
  input  logic                 job_ready
);
  import ntc_pkg::*;

  logic        s1_v_r, s2_v_r;
  logic [1:0]  s1_st_r;
  logic [28:0] s1_vc_r, s1_diff_r;
  job_t        s2_r;
  logic        adv;
  logic [28:0] vc, lim;

  assign adv      = !s2_v_r || job_ready;
  assign in_ready = adv;
  assign vc  = 29'(in_code) * 29'(cfg.adc_ref_mv);
  assign lim = 29'(cfg.supply_mv) * 29'(CODE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_code > CODE_MAX) s1_st_r <= ST_RANGE;
      else if (vc >= lim)     s1_st_r <= ST_RATIO;
      else                    s1_st_r <= ST_OK;
      s1_vc_r   <= vc;
      s1_diff_r <= lim - vc;
      s2_r.num  <= 53'(s1_vc_r) * 53'(cfg.series_ohms);
      s2_r.den  <= 49'(s1_diff_r) * 49'(cfg.ntc_nominal_ohms);
      if (s1_st_r == ST_OK && (s1_vc_r == '0 || cfg.series_ohms == '0 ||
                               cfg.ntc_nominal_ohms == '0))
        s2_r.status <= ST_RATIO;
      else
        s2_r.status <= s1_st_r;
    end
  end

  assign job_valid = s2_v_r;
  assign job       = s2_r;
endmodule

// ===== rtl/core/ntc_fifo.sv =====
// Short queue between the front and back ends.
// Depends on ntc_pkg; depth must be a power of two, which the block itself does not enforce.
module ntc_fifo #(parameter int DEPTH = 4) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  input  ntc_pkg::job_t wr_data,
  output logic          wr_ready,
  output logic          rd_valid,
  output ntc_pkg::job_t rd_data,
  input  logic          rd_ready
);
  import ntc_pkg::*;
  localparam int AW = $clog2(DEPTH);

  job_t        mem_r [DEPTH];
  logic [AW:0] wp_r, rp_r;
  logic        wr, rd;

  assign wr_ready = (wp_r - rp_r) != (AW+1)'(DEPTH);
  assign rd_valid = wp_r != rp_r;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r[AW-1:0]] <= wr_data;
  end
endmodule

// ===== rtl/core/ntc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; a stall enable holds all stages, tag bits ride along.
module ntc_divider #(
  parameter int NW = 64,
  parameter int DW = 48,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_v,
  output logic [NW-1:0] out_q,
  output logic [TW-1:0] out_tag
);
  logic          v_r   [NW+1];
  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    v_r[0] = in_v; q_r[0] = in_num; rem_r[0] = '0; d_r[0] = in_den; t_r[0] = in_tag;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   sh;
    assign sh    = {rem_r[s][DW-1:0], q_r[s][NW-1]};
    assign trial = {1'b0, sh} - {2'b0, d_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else if (en) v_r[s+1] <= v_r[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s+1] <= d_r[s];
        t_r[s+1] <= t_r[s];
        if (!trial[DW+1]) begin
          rem_r[s+1] <= trial[DW:0];
          q_r[s+1]   <= {q_r[s][NW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= sh;
          q_r[s+1]   <= {q_r[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v   = v_r[NW];
  assign out_q   = q_r[NW];
  assign out_tag = t_r[NW];
endmodule

// ===== rtl/core/ntc_back.sv =====
// Back end: log2 by table and interpolation, ln scaling, beta equation,
// final division and saturation. Depends on ntc_pkg and ntc_divider.
module ntc_back #(parameter int LOG_TABLE_ENTRIES = 256) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ntc_pkg::cfg_t              cfg,
  input  logic                       job_valid,
  input  ntc_pkg::job_t              job,
  output logic                       job_ready,
  output logic                       res_valid,
  output logic signed [17:0]         res_temp,
  output logic [1:0]                 res_status,
  input  logic                       res_ready
);
  import ntc_pkg::*;
  localparam int N  = LOG_TABLE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int RW = $clog2(N + 1);
  localparam int ST = 10;               // stages before the divider

  logic en;
  logic [31:0] rom [N+1];
  for (genvar g = 0; g <= N; g++) begin : g_rom
    assign rom[g] = log_rom_word(g, N);
  end

  // stage valid and status pipeline
  logic       v_r  [ST+1];
  logic [1:0] st_r [ST+1];
  assign v_r[0]  = job_valid;
  assign st_r[0] = job.status;
  for (genvar s = 0; s < ST; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else if (en) v_r[s+1] <= v_r[s];
    end
    always_ff @(posedge clk) begin
      if (en) st_r[s+1] <= st_r[s];
    end
  end

  // stage 1: leading-one position and 32-bit mantissa of both operands
  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [5:0] e;
    e = '0;
    for (int k = 0; k < 64; k++) if (x[k]) e = 6'(k);
    return e;
  endfunction

  logic [5:0]  en_e_r, ed_e_r;
  logic [31:0] fn_r, fd_r;
  logic [63:0] nx, dx;
  logic [5:0]  ne, de;
  logic [95:0] nsh, dsh;
  assign nx = 64'(job.num);
  assign dx = 64'(job.den);
  assign ne = msb64(nx);
  assign de = msb64(dx);
  assign nsh = {nx, 32'd0} >> ne;
  assign dsh = {dx, 32'd0} >> de;
  always_ff @(posedge clk) begin
    if (en) begin
      en_e_r <= ne; ed_e_r <= de;
      fn_r <= nsh[31:0]; fd_r <= dsh[31:0];
    end
  end

  // stage 2: table lookup; mantissa times N splits into index and fraction
  logic [IW+31:0] pn, pd;
  logic [IW-1:0]  in_idx, id_idx;
  logic [31:0]    rn_frac, rd_frac;
  assign pn = (IW+32)'(fn_r) * (IW+32)'(N);
  assign pd = (IW+32)'(fd_r) * (IW+32)'(N);
  assign in_idx = pn[IW+31:32];
  assign id_idx = pd[IW+31:32];
  assign rn_frac = pn[31:0];
  assign rd_frac = pd[31:0];
  logic [31:0] n0_r, n1_r, d0_r, d1_r, nr_r, dr_r;
  logic [5:0]  ne2_r, de2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= rom[in_idx]; n1_r <= rom[RW'(in_idx) + RW'(1)];
      d0_r <= rom[id_idx]; d1_r <= rom[RW'(id_idx) + RW'(1)];
      nr_r <= rn_frac; dr_r <= rd_frac;
      ne2_r <= en_e_r; de2_r <= ed_e_r;
    end
  end

  // stage 3: interpolation products (table is increasing)
  logic [63:0] np_r, dp_r;
  logic [31:0] n0b_r, d0b_r;
  logic [5:0]  ne3_r, de3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      np_r <= 64'(n1_r - n0_r) * 64'(nr_r);
      dp_r <= 64'(d1_r - d0_r) * 64'(dr_r);
      n0b_r <= n0_r; d0b_r <= d0_r; ne3_r <= ne2_r; de3_r <= de2_r;
    end
  end

  // stage 4: log2 values and difference
  logic signed [37:0] d_r;
  logic [36:0] ln2n, ln2d;
  assign ln2n = {ne3_r, 30'd0} + 37'(n0b_r) + 37'(np_r[63:32]);
  assign ln2d = {de3_r, 30'd0} + 37'(d0b_r) + 37'(dp_r[63:32]);
  always_ff @(posedge clk) begin
    if (en) d_r <= $signed({1'b0, ln2n}) - $signed({1'b0, ln2d});
  end

  // stage 5: magnitude rounded to Q24
  logic [31:0] mag_r;
  logic        neg5_r;
  logic [37:0] absd;
  assign absd = d_r[37] ? 38'(-d_r) : 38'(d_r);
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= 32'((absd + 38'd32) >> 6);
      neg5_r <= d_r[37];
    end
  end

  // stage 6: times ln2
  logic [63:0] lnp_r;
  logic        neg6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      lnp_r  <= 64'(mag_r) * 64'(LN2_Q32);
      neg6_r <= neg5_r;
    end
  end

  // stage 7: L = ln(R) in Q24, T0c in centikelvin
  logic signed [32:0] l_r;
  logic signed [16:0] t0c_r;
  logic [31:0] lm;
  assign lm = 32'((lnp_r + 64'h8000_0000) >> 32);
  always_ff @(posedge clk) begin
    if (en) begin
      l_r   <= neg6_r ? -$signed({1'b0, lm}) : $signed({1'b0, lm});
      t0c_r <= 17'(cfg.ntc_ref_centi_c) + $signed({2'b0, KELVIN_OFFSET_CENTI});
    end
  end

  // stage 8: T0c*L and 100*beta*T0c
  logic signed [49:0] tl_r;
  logic signed [37:0] bt_r;
  logic [20:0] b100;
  assign b100 = 21'(cfg.beta_kelvin) * 21'd100;
  always_ff @(posedge clk) begin
    if (en) begin
      tl_r   <= 50'(t0c_r) * 50'(l_r);
      bt_r   <= $signed({17'b0, b100}) * 38'(t0c_r);
    end
  end

  // stage 9: D and numerator
  logic signed [51:0] dd_r;
  logic signed [62:0] nm_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dd_r <= $signed({7'b0, b100, 24'd0}) + 52'(tl_r);
      nm_r <= 63'(bt_r) <<< 24;
    end
  end

  // stage 10: divider operands; handle non-positive D and sign
  logic        dpos_r, nneg_r;
  logic [63:0] dn_r;
  logic [47:0] dv_r;
  logic [62:0] nabs;
  assign nabs = nm_r[62] ? 63'(-nm_r) : 63'(nm_r);
  always_ff @(posedge clk) begin
    if (en) begin
      dpos_r <= !dd_r[51] && dd_r != '0;
      nneg_r <= nm_r[62];
      dv_r   <= dd_r[47:0];
      // rounding to nearest: dd/2 is added to the magnitude when positive, subtracted when negative
      if (nm_r[62]) dn_r <= 64'(nabs) - 64'(dd_r[51:1]);
      else          dn_r <= 64'(nabs) + 64'(dd_r[51:1]);
    end
  end

  logic        q_v;
  logic [63:0] q;
  logic [3:0]  q_tag;
  logic        s10_v;
  assign s10_v = v_r[ST];
  ntc_divider #(.NW(64), .DW(48), .TW(4)) u_div (
    .clk, .rst_n, .en,
    .in_v(s10_v), .in_num(dn_r), .in_den(dpos_r ? dv_r : 48'd1),
    .in_tag({st_r[ST], dpos_r, nneg_r}),
    .out_v(q_v), .out_q(q), .out_tag(q_tag)
  );

  // final: apply sign, offset and saturation (zero for error status) into the output register
  logic signed [65:0] tk, temp;
  assign tk   = q_tag[0] ? -$signed({2'b0, q}) : $signed({2'b0, q});
  assign temp = tk - 66'sd27315;

  logic               o_v_r;
  logic signed [17:0] o_t_r;
  logic [1:0]         o_s_r;
  assign en = !o_v_r || res_ready;
  assign job_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= q_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_s_r <= q_tag[3:2];
      if (q_tag[3:2] != ST_OK) o_t_r <= '0;
      else if (!q_tag[1])      o_t_r <= TEMP_HIGH;
      else if (temp > 66'(TEMP_HIGH)) o_t_r <= TEMP_HIGH;
      else if (temp < 66'(TEMP_LOW))  o_t_r <= TEMP_LOW;
      else                     o_t_r <= temp[17:0];
    end
  end

  assign res_valid  = o_v_r;
  assign res_temp   = o_t_r;
  assign res_status = o_s_r;
endmodule
